/* sv/ray_sphere_closest_hit_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ray/sphere closest hit block
// Implication checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_CLOSEST_HIT_TOP_ASSERT_SVH
`define RAY_SPHERE_CLOSEST_HIT_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define RSCH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsch same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define RSCH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsch next-cycle check failed");

`endif

/* sv/rsch_pkg.sv */
// ----------------------------------------------------------------------------
// rsch_pkg
// Widths, step codes, state types and the queue entry of the closest hit block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsch_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int DIR_W     = 18;
    localparam int RAD_W     = 31;
    localparam int IDX_W     = 10;
    localparam int DIST_W    = 31;
    localparam int DIFF_W    = 33;
    localparam int ADJ_W     = 51;
    localparam int MAG_W     = 50;
    localparam int HALF_W    = 25;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 68;
    localparam int DISC_W    = 104;
    localparam int ROOT_W    = 52;
    localparam int REM_W     = 54;
    localparam int PICK_W    = 53;

    // Multiplier schedule of the front end
    localparam logic [3:0] STEP_LXDX = 4'd0;
    localparam logic [3:0] STEP_LYDY = 4'd1;
    localparam logic [3:0] STEP_LZDZ = 4'd2;
    localparam logic [3:0] STEP_LXLX = 4'd3;
    localparam logic [3:0] STEP_LYLY = 4'd4;
    localparam logic [3:0] STEP_LZLZ = 4'd5;
    localparam logic [3:0] STEP_RR   = 4'd6;
    localparam logic [3:0] STEP_HIHI = 4'd7;
    localparam logic [3:0] STEP_HILO = 4'd8;
    localparam logic [3:0] STEP_LOLO = 4'd9;
    localparam logic [3:0] STEP_DONE = 4'd10;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_MUL,
        FE_PUSH
    } rsch_fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_SQRT,
        BE_PICK,
        BE_EMIT
    } rsch_be_state_t;

    typedef struct packed {
        logic                     last;
        logic signed [ADJ_W-1:0]  adj;
        logic signed [DISC_W-1:0] disc;
    } rsch_entry_t;

endpackage

`default_nettype wire

/* sv/rsch_if.sv */
// ----------------------------------------------------------------------------
// rsch channel interfaces
// Valid/ready channels for the ray/sphere requests and the hit results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsch_ray_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [rsch_pkg::COORD_W-1:0]        origin_x;
    logic signed [rsch_pkg::COORD_W-1:0]        origin_y;
    logic signed [rsch_pkg::COORD_W-1:0]        origin_z;
    logic signed [rsch_pkg::DIR_W-1:0]          dir_x;
    logic signed [rsch_pkg::DIR_W-1:0]          dir_y;
    logic signed [rsch_pkg::DIR_W-1:0]          dir_z;
    logic signed [rsch_pkg::COORD_W-1:0]        center_x;
    logic signed [rsch_pkg::COORD_W-1:0]        center_y;
    logic signed [rsch_pkg::COORD_W-1:0]        center_z;
    logic        [rsch_pkg::RAD_W-1:0]          sphere_radius;
    logic                                       last_object;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius, last_object,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius, last_object,
        output ready
    );
endinterface

interface rsch_hit_if;
    logic                            valid;
    logic                            ready;
    logic                            hit_found;
    logic [rsch_pkg::IDX_W-1:0]      hit_index;
    logic [rsch_pkg::DIST_W-1:0]     hit_distance;

    modport source (
        output valid, hit_found, hit_index, hit_distance,
        input  ready
    );
    modport sink (
        input  valid, hit_found, hit_index, hit_distance,
        output ready
    );
endinterface

`default_nettype wire

/* sv/rsch_front.sv */
// ----------------------------------------------------------------------------
// rsch_front
// Accepts a request and forms the projection and the discriminant with one
// shared multiplier over ten steps, then hands the result to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rsch_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    rsch_ray_if.sink                  ray_in,
    output logic                      push_valid,
    output rsch_pkg::rsch_entry_t     push_entry,
    input  wire logic                 push_ready
);

    rsch_pkg::rsch_fe_state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;

    logic signed [rsch_pkg::DIFF_W-1:0] lx_reg, ly_reg, lz_reg;
    logic signed [rsch_pkg::DIR_W-1:0]  dx_reg, dy_reg, dz_reg;
    logic        [rsch_pkg::RAD_W-1:0]  r_reg;
    logic                               last_reg;

    logic signed [rsch_pkg::MUL_W-1:0]  op_a, op_b;
    logic signed [rsch_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [rsch_pkg::ADJ_W-1:0]  adj_reg, adj_next;
    logic signed [rsch_pkg::DISC_W-1:0] disc_reg, disc_next, prod_ext;
    logic        [rsch_pkg::ADJ_W-1:0]  adj_neg;
    logic        [rsch_pkg::MAG_W-1:0]  adj_mag;
    logic signed [rsch_pkg::MUL_W-1:0]  mag_hi, mag_lo;
    logic [3:0]                         prev_step;
    logic                               accept;

    assign accept       = ray_in.valid && ray_in.ready;
    assign ray_in.ready = (state_reg == rsch_pkg::FE_IDLE);

    // Split the projection magnitude into two halves for its square
    assign adj_neg = rsch_pkg::ADJ_W'(-adj_reg);
    assign adj_mag = adj_reg[rsch_pkg::ADJ_W-1] ? adj_neg[rsch_pkg::MAG_W-1:0]
                                               : adj_reg[rsch_pkg::MAG_W-1:0];
    assign mag_hi  = $signed(rsch_pkg::MUL_W'(adj_mag[rsch_pkg::MAG_W-1:rsch_pkg::HALF_W]));
    assign mag_lo  = $signed(rsch_pkg::MUL_W'(adj_mag[rsch_pkg::HALF_W-1:0]));

    // Select the multiplier operands of the current step
    always_comb
    begin
        unique case (step_reg)
            rsch_pkg::STEP_LXDX: begin op_a = rsch_pkg::MUL_W'(lx_reg); op_b = rsch_pkg::MUL_W'(dx_reg); end
            rsch_pkg::STEP_LYDY: begin op_a = rsch_pkg::MUL_W'(ly_reg); op_b = rsch_pkg::MUL_W'(dy_reg); end
            rsch_pkg::STEP_LZDZ: begin op_a = rsch_pkg::MUL_W'(lz_reg); op_b = rsch_pkg::MUL_W'(dz_reg); end
            rsch_pkg::STEP_LXLX: begin op_a = rsch_pkg::MUL_W'(lx_reg); op_b = rsch_pkg::MUL_W'(lx_reg); end
            rsch_pkg::STEP_LYLY: begin op_a = rsch_pkg::MUL_W'(ly_reg); op_b = rsch_pkg::MUL_W'(ly_reg); end
            rsch_pkg::STEP_LZLZ: begin op_a = rsch_pkg::MUL_W'(lz_reg); op_b = rsch_pkg::MUL_W'(lz_reg); end
            rsch_pkg::STEP_RR:
            begin
                op_a = $signed(rsch_pkg::MUL_W'(r_reg));
                op_b = $signed(rsch_pkg::MUL_W'(r_reg));
            end
            rsch_pkg::STEP_HIHI: begin op_a = mag_hi; op_b = mag_hi; end
            rsch_pkg::STEP_HILO: begin op_a = mag_hi; op_b = mag_lo; end
            rsch_pkg::STEP_LOLO: begin op_a = mag_lo; op_b = mag_lo; end
            default:             begin op_a = '0;     op_b = '0;     end
        endcase
    end

    assign prod_next = op_a * op_b;
    assign prod_ext  = rsch_pkg::DISC_W'(prod_reg);
    assign prev_step = step_reg - 4'd1;

    // Fold the product of the previous step into the accumulators
    always_comb
    begin
        adj_next  = adj_reg;
        disc_next = disc_reg;
        if (state_reg == rsch_pkg::FE_MUL && step_reg != rsch_pkg::STEP_LXDX)
        begin
            unique case (prev_step)
                rsch_pkg::STEP_LXDX,
                rsch_pkg::STEP_LYDY,
                rsch_pkg::STEP_LZDZ: adj_next  = adj_reg + prod_reg[rsch_pkg::ADJ_W-1:0];
                rsch_pkg::STEP_LXLX,
                rsch_pkg::STEP_LYLY,
                rsch_pkg::STEP_LZLZ: disc_next = disc_reg - (prod_ext <<< (2*rsch_pkg::FRAC_BITS));
                rsch_pkg::STEP_RR:   disc_next = disc_reg + (prod_ext <<< (2*rsch_pkg::FRAC_BITS));
                rsch_pkg::STEP_HIHI: disc_next = disc_reg + (prod_ext <<< (2*rsch_pkg::HALF_W));
                rsch_pkg::STEP_HILO: disc_next = disc_reg + (prod_ext <<< (rsch_pkg::HALF_W + 1));
                rsch_pkg::STEP_LOLO: disc_next = disc_reg + prod_ext;
                default:             disc_next = disc_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        push_valid = 1'b0;
        unique case (state_reg)
            rsch_pkg::FE_IDLE:
            begin
                if (accept)
                begin
                    state_next = rsch_pkg::FE_MUL;
                    step_next  = rsch_pkg::STEP_LXDX;
                end
            end
            rsch_pkg::FE_MUL:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == rsch_pkg::STEP_DONE)
                begin
                    state_next = rsch_pkg::FE_PUSH;
                end
            end
            rsch_pkg::FE_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = rsch_pkg::FE_IDLE;
                end
            end
            default: state_next = rsch_pkg::FE_IDLE;
        endcase
    end

    assign push_entry.last = last_reg;
    assign push_entry.adj  = adj_reg;
    assign push_entry.disc = disc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsch_pkg::FE_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Capture the request and clear the accumulators on accept
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (accept)
        begin
            lx_reg   <= rsch_pkg::DIFF_W'(ray_in.center_x) - rsch_pkg::DIFF_W'(ray_in.origin_x);
            ly_reg   <= rsch_pkg::DIFF_W'(ray_in.center_y) - rsch_pkg::DIFF_W'(ray_in.origin_y);
            lz_reg   <= rsch_pkg::DIFF_W'(ray_in.center_z) - rsch_pkg::DIFF_W'(ray_in.origin_z);
            dx_reg   <= ray_in.dir_x;
            dy_reg   <= ray_in.dir_y;
            dz_reg   <= ray_in.dir_z;
            r_reg    <= ray_in.sphere_radius;
            last_reg <= ray_in.last_object;
            adj_reg  <= '0;
            disc_reg <= '0;
        end
        else
        begin
            adj_reg  <= adj_next;
            disc_reg <= disc_next;
        end
    end

endmodule

`default_nettype wire

/* sv/rsch_queue.sv */
// ----------------------------------------------------------------------------
// rsch_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rsch_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    input  wire rsch_pkg::rsch_entry_t push_entry,
    output logic                      push_ready,
    output logic                      pop_valid,
    output rsch_pkg::rsch_entry_t     pop_entry,
    input  wire logic                 pop_ready
);

    rsch_pkg::rsch_entry_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push_fire, pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Write the entry storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* sv/rsch_back.sv */
// ----------------------------------------------------------------------------
// rsch_back
// Takes the square root one bit per cycle, picks the hit distance, keeps the
// nearest hit of the group and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsch_back #(
    parameter int MAX_OBJECTS = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pop_valid,
    input  wire rsch_pkg::rsch_entry_t pop_entry,
    output logic                      pop_ready,
    rsch_hit_if.source                hit_out
);

    localparam int CNT_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    rsch_pkg::rsch_be_state_t state_reg, state_next;

    logic signed [rsch_pkg::ADJ_W-1:0]  adj_reg;
    logic                               last_reg;
    logic                               miss_reg;
    logic        [rsch_pkg::DISC_W-1:0] rad_reg;
    logic        [rsch_pkg::REM_W-1:0]  rem_reg, rem_next, rem_sh, trial;
    logic        [rsch_pkg::ROOT_W-1:0] root_reg, root_next;
    logic        [5:0]                  iter_reg;
    logic                               root_ge;

    logic        [CNT_W-1:0]            count_reg;
    logic                               best_valid_reg;
    logic        [CNT_W-1:0]            best_index_reg;
    logic        [rsch_pkg::DIST_W-1:0] best_dist_reg;

    logic                               out_valid_reg;
    logic                               out_found_reg;
    logic        [rsch_pkg::IDX_W-1:0]  out_index_reg;
    logic        [rsch_pkg::DIST_W-1:0] out_dist_reg;

    logic signed [rsch_pkg::PICK_W-1:0] near_root, far_root, pick;
    logic        [rsch_pkg::PICK_W-1:0] pick_shift;
    logic        [rsch_pkg::DIST_W-1:0] hit_dist;
    logic                               is_hit, take;
    logic        [31:0]                 count_inc, index_wide;
    logic                               out_free, pop_fire, emit;

    assign pop_ready = (state_reg == rsch_pkg::BE_IDLE);
    assign pop_fire  = pop_valid && pop_ready;
    assign out_free  = !out_valid_reg || hit_out.ready;
    assign emit      = (state_reg == rsch_pkg::BE_EMIT) && out_free;

    // One restoring square root step
    assign rem_sh    = {rem_reg[rsch_pkg::REM_W-3:0], rad_reg[rsch_pkg::DISC_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign root_ge   = (rem_sh >= trial);
    assign rem_next  = root_ge ? (rem_sh - trial) : rem_sh;
    assign root_next = {root_reg[rsch_pkg::ROOT_W-2:0], root_ge};

    // Near and far roots, choice and saturation
    assign near_root  = rsch_pkg::PICK_W'(adj_reg) - $signed(rsch_pkg::PICK_W'(root_reg));
    assign far_root   = rsch_pkg::PICK_W'(adj_reg) + $signed(rsch_pkg::PICK_W'(root_reg));
    assign is_hit     = !miss_reg && !(near_root[rsch_pkg::PICK_W-1] && far_root[rsch_pkg::PICK_W-1]);
    assign pick       = near_root[rsch_pkg::PICK_W-1] ? far_root : near_root;
    assign pick_shift = rsch_pkg::PICK_W'(pick) >> rsch_pkg::FRAC_BITS;
    assign hit_dist   = (pick_shift > rsch_pkg::PICK_W'(rsch_pkg::DIST_MAX))
                        ? rsch_pkg::DIST_MAX : pick_shift[rsch_pkg::DIST_W-1:0];
    assign take       = is_hit && (!best_valid_reg || hit_dist < best_dist_reg);
    assign count_inc  = 32'(count_reg) + 32'd1;
    assign index_wide = 32'(best_index_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsch_pkg::BE_IDLE:
            begin
                if (pop_fire)
                begin
                    state_next = pop_entry.disc[rsch_pkg::DISC_W-1] ? rsch_pkg::BE_PICK
                                                                     : rsch_pkg::BE_SQRT;
                end
            end
            rsch_pkg::BE_SQRT:
            begin
                if (iter_reg == 6'(rsch_pkg::ROOT_W - 1))
                begin
                    state_next = rsch_pkg::BE_PICK;
                end
            end
            rsch_pkg::BE_PICK:
            begin
                state_next = last_reg ? rsch_pkg::BE_EMIT : rsch_pkg::BE_IDLE;
            end
            rsch_pkg::BE_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rsch_pkg::BE_IDLE;
                end
            end
            default: state_next = rsch_pkg::BE_IDLE;
        endcase
    end

    // Control state, running best and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rsch_pkg::BE_IDLE;
            count_reg      <= '0;
            best_valid_reg <= 1'b0;
            best_index_reg <= '0;
            best_dist_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (hit_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == rsch_pkg::BE_PICK)
            begin
                count_reg <= (count_inc >= 32'(MAX_OBJECTS)) ? '0 : count_inc[CNT_W-1:0];
                if (take)
                begin
                    best_valid_reg <= 1'b1;
                    best_index_reg <= count_reg;
                    best_dist_reg  <= hit_dist;
                end
            end
            if (emit)
            begin
                count_reg      <= '0;
                best_valid_reg <= 1'b0;
                best_index_reg <= '0;
                best_dist_reg  <= '0;
            end
        end
    end

    // Square root datapath and result payload
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            adj_reg  <= pop_entry.adj;
            last_reg <= pop_entry.last;
            miss_reg <= pop_entry.disc[rsch_pkg::DISC_W-1];
            rad_reg  <= pop_entry.disc;
            rem_reg  <= '0;
            root_reg <= '0;
            iter_reg <= '0;
        end
        else if (state_reg == rsch_pkg::BE_SQRT)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            iter_reg <= iter_reg + 6'd1;
        end
        if (emit)
        begin
            out_found_reg <= best_valid_reg;
            out_index_reg <= best_valid_reg ? index_wide[rsch_pkg::IDX_W-1:0] : '0;
            out_dist_reg  <= best_valid_reg ? best_dist_reg : '0;
        end
    end

    assign hit_out.valid        = out_valid_reg;
    assign hit_out.hit_found    = out_found_reg;
    assign hit_out.hit_index    = out_index_reg;
    assign hit_out.hit_distance = out_dist_reg;

endmodule

`default_nettype wire

/* sv/ray_sphere_closest_hit_top.sv */
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_top
// Nearest ray/sphere hit over a group of spheres, one sphere per request.
// ----------------------------------------------------------------------------
// Usage:
//   ray_in carries one ray and one sphere per request; last_object closes the
//   group. hit_out carries one result per group: hit flag, index, distance.
//   The front end takes a request, runs ten multiplies on one shared 34x34
//   multiplier and queues the projection and discriminant; it takes no new
//   request until that entry is queued. The back end takes the square root
//   one bit per cycle and then updates the nearest hit; a negative
//   discriminant skips the root. The back end takes no new entry before it
//   is done with the last; the two-entry queue lets the front end run ahead.
//   When the receiver stalls, the result register holds; a further group
//   result waits in the back end, the queue fills, and ray_in.ready drops.
//   Reset clears the group position, the running best and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_sphere_closest_hit_top_assert.svh"

module ray_sphere_closest_hit_top #(
    parameter int MAX_OBJECTS = 1024
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rsch_ray_if.sink      ray_in,
    rsch_hit_if.source    hit_out
);

    logic                  q_push_valid, q_push_ready;
    logic                  q_pop_valid, q_pop_ready;
    rsch_pkg::rsch_entry_t q_push_entry, q_pop_entry;

    rsch_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ray_in     (ray_in),
        .push_valid (q_push_valid),
        .push_entry (q_push_entry),
        .push_ready (q_push_ready)
    );

    rsch_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_entry (q_push_entry),
        .push_ready (q_push_ready),
        .pop_valid  (q_pop_valid),
        .pop_entry  (q_pop_entry),
        .pop_ready  (q_pop_ready)
    );

    rsch_back #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (q_pop_valid),
        .pop_entry  (q_pop_entry),
        .pop_ready  (q_pop_ready),
        .hit_out    (hit_out)
    );

    // A result without a hit carries zero index and distance
    `RSCH_ASSERT_SAME(a_miss_zero, hit_out.valid && !hit_out.hit_found,
        hit_out.hit_index == '0 && hit_out.hit_distance == '0)
    // The front end is busy right after it takes a request
    `RSCH_ASSERT_NEXT(a_front_busy, ray_in.valid && ray_in.ready, !ray_in.ready)
    // A queued entry is visible to the back end on the next cycle
    `RSCH_ASSERT_NEXT(a_queue_seen, q_push_valid && q_push_ready, q_pop_valid)

endmodule

`default_nettype wire

/* verif/rsch_closest_hit_checker.sv */
// ----------------------------------------------------------------------------
// rsch_closest_hit_checker
// Watches the ray and hit channels of the closest hit block, keeps its own
// running nearest hit per group in exact wide arithmetic, and compares every
// accepted hit result against the oldest expected group result.
// ----------------------------------------------------------------------------
`default_nettype none

module rsch_closest_hit_checker #(
    parameter int MAX_OBJECTS = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rsch_ray_if       ray,
    rsch_hit_if       hit,
    output int        fail_count,
    output int        pending_count,
    output int        spheres_seen,
    output int        groups_seen,
    output int        groups_hit
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                        found;
        logic [rsch_pkg::IDX_W-1:0]  index;
        logic [rsch_pkg::DIST_W-1:0] distance;
    } group_result_t;

    group_result_t expected_results[$];

    // running state of the current group
    logic [rsch_pkg::IDX_W-1:0] group_pos;
    logic                       near_valid;
    logic [rsch_pkg::IDX_W-1:0] near_index;
    logic [31:0]                near_distance;

    assign pending_count = expected_results.size();

    // floor square root of a non-negative value below 2^126
    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [127:0] sq;
        root = '0;
        for (int b = 62; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            sq = {64'd0, trial} * {64'd0, trial};
            if (sq <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] hit result mismatch on %s: got %0d, expected %0d",
                 $realtime, what, got, want);
        fail_count++;
    endtask

    // Advance the running nearest hit by one accepted sphere request
    task automatic take_sphere();
        logic signed [127:0] ox, oy, oz, cx, cy, cz, dx, dy, dz, rad;
        logic signed [127:0] lx, ly, lz, adj, ll, disc, thc, near_root, far_root, pick;
        logic        [127:0] dist_wide;
        logic        [31:0]  sphere_dist;
        group_result_t       res;
        ox = ray.origin_x;  oy = ray.origin_y;  oz = ray.origin_z;
        cx = ray.center_x;  cy = ray.center_y;  cz = ray.center_z;
        dx = ray.dir_x;     dy = ray.dir_y;     dz = ray.dir_z;
        rad = {97'd0, ray.sphere_radius};
        lx = cx - ox;
        ly = cy - oy;
        lz = cz - oz;
        adj  = lx * dx + ly * dy + lz * dz;
        ll   = lx * lx + ly * ly + lz * lz;
        disc = ((rad * rad - ll) <<< (2 * rsch_pkg::FRAC_BITS)) + adj * adj;
        if (disc >= 0) begin
            thc = {64'd0, floor_sqrt(disc)};
            near_root = adj - thc;
            far_root  = adj + thc;
            if (!(near_root < 0 && far_root < 0)) begin
                pick = (near_root >= 0) ? near_root : far_root;
                dist_wide = pick >> rsch_pkg::FRAC_BITS;
                sphere_dist = (dist_wide > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : dist_wide[31:0];
                if (!near_valid || sphere_dist < near_distance) begin
                    near_valid    = 1'b1;
                    near_index    = group_pos;
                    near_distance = sphere_dist;
                end
            end
        end
        group_pos = (int'(group_pos) + 1 >= MAX_OBJECTS) ? '0 : group_pos + 1'b1;
        spheres_seen++;
        if (ray.last_object) begin
            res.found    = near_valid;
            res.index    = near_valid ? near_index : '0;
            res.distance = near_valid ? near_distance[rsch_pkg::DIST_W-1:0] : '0;
            expected_results.push_back(res);
            groups_seen++;
            if (near_valid)
                groups_hit++;
            group_pos     = '0;
            near_valid    = 1'b0;
            near_index    = '0;
            near_distance = '0;
        end
    endtask

    initial begin
        fail_count   = 0;
        spheres_seen = 0;
        groups_seen  = 0;
        groups_hit   = 0;
    end

    // Predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n) begin
        group_result_t want;
        if (!rst_n) begin
            group_pos     = '0;
            near_valid    = 1'b0;
            near_index    = '0;
            near_distance = '0;
            expected_results.delete();
        end else begin
            if (ray.valid && ray.ready)
                take_sphere();
            if (hit.valid && hit.ready) begin
                if (expected_results.size() == 0) begin
                    $display("[%0t] hit result with no group pending", $realtime);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (hit.hit_found !== want.found)
                        report_mismatch("hit_found", 32'(hit.hit_found), 32'(want.found));
                    if (hit.hit_index !== want.index)
                        report_mismatch("hit_index", 32'(hit.hit_index), 32'(want.index));
                    if (hit.hit_distance !== want.distance)
                        report_mismatch("hit_distance", 32'(hit.hit_distance),
                                        32'(want.distance));
                end
            end
        end
    end

endmodule

`default_nettype wire

/* verif/ray_sphere_closest_hit_top_tb.sv */
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_top_tb
// Drives ray/sphere requests into the closest hit block: a directed set of
// corner geometries, random groups of mostly well-aimed spheres with random
// noise, idle bursts on both sides and one long receiver hold-off. The
// checker predicts and compares the results.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_closest_hit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 930;
    localparam int QUIET_ITEMS  = 80;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 600;
    localparam int ONE          = 65536;

    typedef struct {
        logic signed [rsch_pkg::COORD_W-1:0] ox, oy, oz;
        logic signed [rsch_pkg::DIR_W-1:0]   dx, dy, dz;
        logic signed [rsch_pkg::COORD_W-1:0] cx, cy, cz;
        logic        [rsch_pkg::RAD_W-1:0]   rad;
        logic                                last;
    } sphere_req_t;

    logic clk;
    logic rst_n;
    logic quiet;
    logic hold_req;
    int   cycle_count;
    int   fail_count, pending_count, spheres_seen, groups_seen, groups_hit;

    rsch_ray_if ray_in ();
    rsch_hit_if hit_out ();

    ray_sphere_closest_hit_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .ray_in  (ray_in),
        .hit_out (hit_out)
    );

    rsch_closest_hit_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .ray           (ray_in),
        .hit           (hit_out),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .spheres_seen  (spheres_seen),
        .groups_seen   (groups_seen),
        .groups_hit    (groups_hit)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Stop a hung run
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("ray_sphere_closest_hit_top test failed");
            $finish;
        end
    end

    function automatic sphere_req_t mk(input longint ox, oy, oz, dx, dy, dz,
                                       input longint cx, cy, cz, rad, input bit last);
        sphere_req_t s;
        s.ox = ox[31:0];  s.oy = oy[31:0];  s.oz = oz[31:0];
        s.dx = dx[17:0];  s.dy = dy[17:0];  s.dz = dz[17:0];
        s.cx = cx[31:0];  s.cy = cy[31:0];  s.cz = cz[31:0];
        s.rad = rad[30:0];
        s.last = last;
        return s;
    endfunction

    // Offer one request, with an occasional idle burst ahead of it
    task automatic send_sphere(input sphere_req_t s);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            ray_in.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        ray_in.valid         <= 1'b1;
        ray_in.origin_x      <= s.ox;
        ray_in.origin_y      <= s.oy;
        ray_in.origin_z      <= s.oz;
        ray_in.dir_x         <= s.dx;
        ray_in.dir_y         <= s.dy;
        ray_in.dir_z         <= s.dz;
        ray_in.center_x      <= s.cx;
        ray_in.center_y      <= s.cy;
        ray_in.center_z      <= s.cz;
        ray_in.sphere_radius <= s.rad;
        ray_in.last_object   <= s.last;
        do @(posedge clk); while (!ray_in.ready);
    endtask

    // Random sphere: mostly placed along the ray, sometimes pure noise
    function automatic sphere_req_t random_sphere(input bit last);
        sphere_req_t s;
        longint ox, oy, oz, dx, dy, dz, t;
        if ($urandom_range(0, 4) == 0) begin
            s.ox = $urandom;  s.oy = $urandom;  s.oz = $urandom;
            s.dx = 18'($signed($urandom_range(0, 2 * ONE)) - ONE);
            s.dy = 18'($signed($urandom_range(0, 2 * ONE)) - ONE);
            s.dz = 18'($signed($urandom_range(0, 2 * ONE)) - ONE);
            s.cx = $urandom;  s.cy = $urandom;  s.cz = $urandom;
            s.rad = 31'($urandom);
            s.last = last;
            return s;
        end
        ox = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        oy = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        oz = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        dx = longint'($urandom_range(0, 2 * ONE)) - ONE;
        dy = longint'($urandom_range(0, 2 * ONE)) - ONE;
        dz = longint'($urandom_range(0, 2 * ONE)) - ONE;
        t  = longint'($urandom_range(0, 1 << 23)) - (1 << 20);
        return mk(ox, oy, oz, dx, dy, dz,
                  ox + ((dx * t) >>> 16) + longint'($urandom_range(0, 1 << 18)) - (1 << 17),
                  oy + ((dy * t) >>> 16) + longint'($urandom_range(0, 1 << 18)) - (1 << 17),
                  oz + ((dz * t) >>> 16) + longint'($urandom_range(0, 1 << 18)) - (1 << 17),
                  $urandom_range(0, 1 << 21), last);
    endfunction

    // Result receiver: random stall bursts and one long hold-off
    initial begin
        hit_out.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hit_out.ready <= 1'b0;
                hold_req      <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                hit_out.ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(posedge clk);
            end else begin
                hit_out.ready <= 1'b1;
            end
        end
    end

    initial begin
        int group_left;
        ray_in.valid         = 1'b0;
        ray_in.origin_x      = '0;
        ray_in.origin_y      = '0;
        ray_in.origin_z      = '0;
        ray_in.dir_x         = '0;
        ray_in.dir_y         = '0;
        ray_in.dir_z         = '0;
        ray_in.center_x      = '0;
        ray_in.center_y      = '0;
        ray_in.center_z      = '0;
        ray_in.sphere_radius = '0;
        ray_in.last_object   = 1'b0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        rst_n    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain hit, tangent ray, sphere behind, origin inside
        send_sphere(mk(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, 2 * ONE, 1));
        send_sphere(mk(0, 0, 0, ONE, 0, 0, 10 * ONE, ONE, 0, ONE, 1));
        send_sphere(mk(0, 0, 0, ONE, 0, 0, -10 * ONE, 0, 0, 2 * ONE, 1));
        send_sphere(mk(0, 0, 0, 0, ONE, 0, 0, ONE, 0, 5 * ONE, 1));
        // No hit in the group
        send_sphere(mk(0, 0, 0, 0, 0, ONE, 50 * ONE, 0, 0, ONE, 0));
        send_sphere(mk(0, 0, 0, 0, 0, ONE, 0, 0, -9 * ONE, ONE, 1));
        // Equal distances keep the earlier sphere; a nearer later one wins
        send_sphere(mk(0, 0, 0, ONE, 0, 0, 20 * ONE, 0, 0, ONE, 0));
        send_sphere(mk(0, 0, 0, ONE, 0, 0, 20 * ONE, 0, 0, ONE, 0));
        send_sphere(mk(0, 0, 0, ONE, 0, 0, 8 * ONE, 0, 0, ONE, 0));
        send_sphere(mk(0, 0, 0, ONE, 0, 0, 8 * ONE, 0, 0, ONE, 1));
        // Saturated distance, negative direction extremes
        send_sphere(mk(-64'sd2147483648, 0, 0, ONE, 0, 0, 2147483647, 0, 0, 7, 1));
        send_sphere(mk(2147483647, 2147483647, 2147483647, -ONE, -ONE, -ONE,
                       -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                       2147483647, 1));
        send_sphere(mk(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                       ONE, ONE, ONE, 2147483647, 2147483647, 2147483647, 0, 1));
        // Non-unit direction, zero radius, zero direction, all-zero request
        send_sphere(mk(0, 0, 0, ONE, ONE, 0, 30 * ONE, 30 * ONE, 0, 3 * ONE, 1));
        send_sphere(mk(ONE, ONE, ONE, 0, 0, -ONE, ONE, ONE, -40 * ONE, 0, 1));
        send_sphere(mk(0, 0, 0, 0, 0, 0, 3 * ONE, 0, 0, 4 * ONE, 1));
        send_sphere(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        send_sphere(mk(0, 0, 0, -ONE, 0, 0, 0, 0, 0, 2147483647, 1));

        // Random groups; one long receiver hold-off in the middle
        group_left = $urandom_range(1, 6);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3)
                hold_req <= 1'b1;
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet <= 1'b1;
            group_left--;
            send_sphere(random_sphere(group_left == 0));
            if (group_left == 0)
                group_left = $urandom_range(1, 6);
        end
        if (group_left != 0)
            send_sphere(random_sphere(1'b1));

        send_sphere(mk(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, 1));
        ray_in.valid <= 1'b0;
        @(posedge clk);

        // Drain the results, then a latency's worth of quiet
        while (pending_count != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("covered %0d sphere requests in %0d groups, %0d of them with a hit",
                 spheres_seen, groups_seen, groups_hit);
        if (fail_count == 0)
            $display("ray_sphere_closest_hit_top test passed");
        else
            $display("ray_sphere_closest_hit_top test failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+sv
sv/rsch_pkg.sv
sv/rsch_if.sv
sv/rsch_front.sv
sv/rsch_queue.sv
sv/rsch_back.sv
sv/ray_sphere_closest_hit_top.sv
verif/rsch_closest_hit_checker.sv
verif/ray_sphere_closest_hit_top_tb.sv
